/* src/isl_pkg.sv */
`timescale 1ns / 1ps
package isl_pkg;

  // storage geometry
  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  // fixed field widths
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;

  // cell index and compare widths
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CAP_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CAP_W > POS_W) ? CAP_W : POS_W;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } isl_status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_ERASE  = 1'b1
  } isl_kind_e;

  // broadcast control to every cell
  typedef struct packed {
    logic                  en;
    isl_kind_e             kind;
    logic [CMP_W-1:0]      pos;
    logic [VALUE_BITS-1:0] value;
  } isl_ctl_t;

endpackage

/* src/isl_cell.sv */
`timescale 1ns / 1ps
module isl_cell
  import isl_pkg::*;
(
  input  logic                  clk_i,
  input  isl_ctl_t              ctl_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [CMP_W-1:0]      count_i,
  input  logic [VALUE_BITS-1:0] left_i,
  input  logic [VALUE_BITS-1:0] right_i,
  output logic [VALUE_BITS-1:0] data_o,
  output logic [VALUE_BITS-1:0] tap_o
);

  logic [VALUE_BITS-1:0] data_q, data_d;
  logic [CMP_W-1:0]      my_idx;

  assign my_idx = CMP_W'(idx_i);

  // shift in from a neighbor, take the new value, or hold
  always_comb begin
    data_d = data_q;
    if (ctl_i.en) begin
      unique case (ctl_i.kind)
        KIND_INSERT: begin
          if (my_idx > ctl_i.pos) begin
            data_d = left_i;
          end else if (my_idx == ctl_i.pos) begin
            data_d = ctl_i.value;
          end
        end
        KIND_ERASE: begin
          if (my_idx >= ctl_i.pos) begin
            data_d = right_i;
          end
        end
        default: data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // drive the back value when this cell holds the last entry
  assign tap_o = (count_i == my_idx + CMP_W'(1)) ? data_q : '0;

endmodule

/* src/indexed_sequence_list.sv */
`timescale 1ns / 1ps
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o   | kind_i, position_i, value_i
// out     | output    | out_valid_o / out_ready_i | status_o, count_o, front_value_o,
//         |           |                           | back_value_o
//
// The cell row shifts at the accepting edge; the result register is then loaded
// from the front cell and the last cell once the result side has room.
// A new item is taken only after the previous one has been loaded into the result register.
// Reset clears the count and the handshake state; cell contents are left as is.
// A stalled result holds the next item in the cell row until the result moves.
module indexed_sequence_list
  import isl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [CNT_W-1:0] count_o,
  output logic [VAL_W-1:0] front_value_o,
  output logic [VAL_W-1:0] back_value_o
);

  logic [CMP_W-1:0] count_q, count_d;
  isl_status_e      st_q, st_d;
  logic             pend_q;
  logic             out_valid_q;
  logic             in_acc;
  logic             out_load;
  logic [CMP_W-1:0] pos_w;
  isl_ctl_t         ctl;

  logic [VALUE_BITS-1:0] data [CAPACITY];
  logic [VALUE_BITS-1:0] tap  [CAPACITY];
  logic [VALUE_BITS-1:0] back_or;

  assign in_ready_o = !pend_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = pend_q && (!out_valid_q || out_ready_i);
  assign pos_w      = CMP_W'(position_i);

  // decide status and the new count
  always_comb begin
    st_d    = ST_DONE;
    count_d = count_q;
    unique case (isl_kind_e'(kind_i))
      KIND_INSERT: begin
        if (pos_w > count_q) begin
          st_d = ST_RANGE;
        end else if (count_q >= CMP_W'(CAPACITY)) begin
          st_d = ST_FULL;
        end else begin
          count_d = count_q + CMP_W'(1);
        end
      end
      KIND_ERASE: begin
        if (pos_w >= count_q) begin
          st_d = ST_RANGE;
        end else begin
          count_d = count_q - CMP_W'(1);
        end
      end
      default: st_d = ST_DONE;
    endcase
  end

  // control broadcast to the row
  always_comb begin
    ctl.en    = in_acc && (st_d == ST_DONE);
    ctl.kind  = isl_kind_e'(kind_i);
    ctl.pos   = pos_w;
    ctl.value = value_i[VALUE_BITS-1:0];
  end

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = data[g+1];
    end
    isl_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (IDX_W'(g)),
      .count_i (count_q),
      .left_i  (left_v),
      .right_i (right_v),
      .data_o  (data[g]),
      .tap_o   (tap[g])
    );
  end

  // collect the back value from the one tapped cell
  always_comb begin
    back_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_or = back_or | tap[i];
    end
  end

  // count, status, pending flag and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      st_q        <= ST_DONE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q <= count_d;
        st_q    <= st_d;
        pend_q  <= 1'b1;
      end else if (out_load) begin
        pend_q  <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o      <= st_q;
      count_o       <= CNT_W'(count_q);
      front_value_o <= (count_q != '0) ? VAL_W'(data[0]) : '0;
      back_value_o  <= VAL_W'(back_or);
    end
  end

  assign out_valid_o = out_valid_q;

  // count never exceeds the capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMP_W'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted item is pending in the next cycle
  a_pend_after_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pend_q)
    else $error("accepted item not pending");

  // a successful insert grows the count by one
  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_INSERT && st_d == ST_DONE)
      |=> count_q == $past(count_q) + CMP_W'(1))
    else $error("insert did not grow the count");

  // a pending result is loaded once the output side frees up
  a_pend_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !out_valid_q) |=> (!pend_q && out_valid_q))
    else $error("pending result not loaded");

endmodule
